### design/lrg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrg_pkg;

    localparam int DATA_W = 64;
    localparam int CNT_W  = $clog2(DATA_W);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 2'd2;

    localparam logic CMD_GENERATE = 1'b0;
    localparam logic CMD_RESEED   = 1'b1;

    localparam logic [DATA_W-1:0] RESET_SEED = {{(DATA_W-1){1'b0}}, 1'b1};

    // One datapath operation each; remainders first, then the affine map updates.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_REM_MULT,
        OP_REM_INCR,
        OP_REM_POS,
        OP_REM_SEED,
        OP_RC_STEP,
        OP_RA_STEP,
        OP_BC_STEP,
        OP_BA_STEP,
        OP_RC_LAST,
        OP_RA_LAST,
        OP_POS_LAST
    } op_t;

    typedef struct packed {
        logic capture;
        logic start;
        op_t  op;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic done;
        logic k_zero;
        logic k_lsb;
        logic reseed;
    } ctrl_stat_t;

    function automatic logic op_is_rem(input op_t op);
        return (op == OP_REM_MULT) || (op == OP_REM_INCR) ||
               (op == OP_REM_POS) || (op == OP_REM_SEED);
    endfunction

endpackage

`default_nettype wire

### design/lrg_modunit.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial modular unit. Multiply: double-and-add, MSB first, one modular
// add per cycle, optional final "+ addend". Remainder: shifts op_y in bit by bit.
module lrg_modunit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         rem_mode,
    input  wire logic                         add_en,
    input  wire logic [lrg_pkg::DATA_W-1:0]   op_x,
    input  wire logic [lrg_pkg::DATA_W-1:0]   op_y,
    input  wire logic [lrg_pkg::DATA_W-1:0]   addend,
    input  wire logic [lrg_pkg::DATA_W:0]     mod_ext,
    output logic                              done,
    output logic [lrg_pkg::DATA_W-1:0]        result
);
    import lrg_pkg::*;

    typedef enum logic [2:0] {
        U_IDLE,
        U_DBL,
        U_ADD,
        U_POST,
        U_DONE
    } ustate_t;

    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DATA_W - 1);

    ustate_t           state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0] y_reg;
    logic [DATA_W-1:0] add_reg;
    logic              rem_reg;
    logic              post_reg;

    logic [DATA_W-1:0] v_sel;
    logic              cin;
    logic [DATA_W:0]   sum;
    logic [DATA_W:0]   sum_red;
    logic [DATA_W-1:0] addm_res;

    always_comb
    begin
        unique case (state_reg)
            U_DBL:   v_sel = acc_reg;
            U_ADD:   v_sel = x_reg;
            U_POST:  v_sel = add_reg;
            default: v_sel = '0;
        endcase
    end

    assign cin = (state_reg == U_DBL) && rem_reg && y_reg[cnt_reg];
    // both terms below mod_ext, so one conditional subtract reduces the sum
    assign sum = {1'b0, acc_reg} + {1'b0, v_sel} + {{DATA_W{1'b0}}, cin};
    assign sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
    assign addm_res = sum_red[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                U_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= U_DBL;
                        cnt_reg   <= CNT_TOP;
                    end
                end
                U_DBL:
                begin
                    if (!rem_reg && y_reg[cnt_reg])
                        state_reg <= U_ADD;
                    else if (cnt_reg == '0)
                        state_reg <= post_reg ? U_POST : U_DONE;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                U_ADD:
                begin
                    if (cnt_reg == '0)
                        state_reg <= post_reg ? U_POST : U_DONE;
                    else
                    begin
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= U_DBL;
                    end
                end
                U_POST:  state_reg <= U_DONE;
                U_DONE:  state_reg <= U_IDLE;
                default: state_reg <= U_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == U_IDLE && start)
        begin
            acc_reg  <= '0;
            x_reg    <= op_x;
            y_reg    <= op_y;
            add_reg  <= addend;
            rem_reg  <= rem_mode;
            post_reg <= add_en && !rem_mode;
        end
        else if (state_reg == U_DBL || state_reg == U_ADD || state_reg == U_POST)
        begin
            acc_reg <= addm_res;
        end
    end

    assign done   = (state_reg == U_DONE);
    assign result = acc_reg;

endmodule

`default_nettype wire

### design/lrg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lrg_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lrg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lrg_pkg::DATA_W-1:0]      cfg_data,
    input  wire logic                            cmd,
    input  wire logic [lrg_pkg::DATA_W-1:0]      operand,
    input  wire lrg_pkg::ctrl_cmd_t              ctl,
    output lrg_pkg::ctrl_stat_t                  stat,
    output logic [lrg_pkg::DATA_W-1:0]           position
);
    import lrg_pkg::*;

    logic [DATA_W-1:0] mult_reg;
    logic [DATA_W-1:0] incr_reg;
    logic [DATA_W-1:0] mod_reg;
    logic [DATA_W-1:0] pos_reg;

    logic              reseed_reg;
    logic [DATA_W-1:0] seed_reg;
    logic              seedz_reg;
    logic [DATA_W-1:0] k_reg;
    logic [DATA_W-1:0] ba_reg;
    logic [DATA_W-1:0] bc_reg;
    logic [DATA_W-1:0] ra_reg;
    logic [DATA_W-1:0] rc_reg;
    logic [DATA_W-1:0] a0_reg;
    logic [DATA_W-1:0] c0_reg;
    logic [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0] npos_reg;
    logic [DATA_W-1:0] out_pos_reg;

    logic [DATA_W:0]   mod_ext;
    logic [DATA_W-1:0] one_red;
    logic [DATA_W-1:0] u_x;
    logic [DATA_W-1:0] u_y;
    logic [DATA_W-1:0] u_add;
    logic              u_add_en;
    logic              u_done;
    logic [DATA_W-1:0] u_res;
    logic [DATA_W-1:0] new_pos;

    // modulus 0 stands for 2^64
    assign mod_ext = {(mod_reg == '0), mod_reg};
    assign one_red = (mod_reg == RESET_SEED) ? '0 : RESET_SEED;

    always_comb
    begin
        u_x      = '0;
        u_y      = '0;
        u_add    = '0;
        u_add_en = 1'b0;
        case (ctl.op)
            OP_REM_MULT: u_y = mult_reg;
            OP_REM_INCR: u_y = incr_reg;
            OP_REM_POS:  u_y = pos_reg;
            OP_REM_SEED: u_y = seed_reg;
            OP_RC_STEP:
            begin
                u_x = ba_reg; u_y = rc_reg; u_add = bc_reg; u_add_en = 1'b1;
            end
            OP_RA_STEP:
            begin
                u_x = ba_reg; u_y = ra_reg;
            end
            OP_BC_STEP:
            begin
                u_x = ba_reg; u_y = bc_reg; u_add = bc_reg; u_add_en = 1'b1;
            end
            OP_BA_STEP:
            begin
                u_x = ba_reg; u_y = ba_reg;
            end
            OP_RC_LAST:
            begin
                u_x = a0_reg; u_y = rc_reg; u_add = c0_reg; u_add_en = 1'b1;
            end
            OP_RA_LAST:
            begin
                u_x = a0_reg; u_y = ra_reg;
            end
            OP_POS_LAST:
            begin
                u_x = ra_reg; u_y = x_reg; u_add = rc_reg; u_add_en = 1'b1;
            end
            default: ;
        endcase
    end

    lrg_modunit u_modunit (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.start),
        .rem_mode (op_is_rem(ctl.op)),
        .add_en   (u_add_en),
        .op_x     (u_x),
        .op_y     (u_y),
        .addend   (u_add),
        .mod_ext  (mod_ext),
        .done     (u_done),
        .result   (u_res)
    );

    assign new_pos = reseed_reg ? (((c0_reg == '0) && seedz_reg) ? RESET_SEED : seed_reg)
                                : npos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= '0;
            incr_reg <= '0;
            mod_reg  <= RESET_SEED;
            pos_reg  <= RESET_SEED;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MULTIPLIER: mult_reg <= cfg_data;
                    CFG_INCREMENT:  incr_reg <= cfg_data;
                    CFG_MODULUS:    mod_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (ctl.commit)
                pos_reg <= new_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            reseed_reg <= (cmd == CMD_RESEED);
            seed_reg   <= operand;
            k_reg      <= operand;
            ra_reg     <= one_red;
            rc_reg     <= '0;
        end
        if (u_done)
        begin
            case (ctl.op)
                OP_REM_MULT:
                begin
                    ba_reg <= u_res; a0_reg <= u_res;
                end
                OP_REM_INCR:
                begin
                    bc_reg <= u_res; c0_reg <= u_res;
                end
                OP_REM_POS:  x_reg     <= u_res;
                OP_REM_SEED: seedz_reg <= (u_res == '0);
                OP_RC_STEP:  rc_reg    <= u_res;
                OP_RA_STEP:  ra_reg    <= u_res;
                OP_BC_STEP:  bc_reg    <= u_res;
                OP_BA_STEP:
                begin
                    ba_reg <= u_res;
                    k_reg  <= k_reg >> 1;
                end
                OP_RC_LAST:  rc_reg    <= u_res;
                OP_RA_LAST:  ra_reg    <= u_res;
                OP_POS_LAST: npos_reg  <= u_res;
                default: ;
            endcase
        end
        if (ctl.commit)
            out_pos_reg <= new_pos;
    end

    assign stat.done   = u_done;
    assign stat.k_zero = (k_reg == '0);
    assign stat.k_lsb  = k_reg[0];
    assign stat.reseed = reseed_reg;
    assign position    = out_pos_reg;

endmodule

`default_nettype wire

### design/lrg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lrg_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire lrg_pkg::ctrl_stat_t  stat,
    output lrg_pkg::ctrl_cmd_t        ctl
);
    import lrg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg;
    op_t    op_reg;
    logic   out_valid_reg;
    op_t    op_next;
    logic   finish;
    logic   out_free;

    // loop test after the position remainder and after each squaring
    function automatic op_t loop_op(input ctrl_stat_t s);
        if (s.k_zero)
            return OP_RC_LAST;
        else if (s.k_lsb)
            return OP_RC_STEP;
        else
            return OP_BC_STEP;
    endfunction

    always_comb
    begin
        finish  = 1'b0;
        op_next = OP_NONE;
        case (op_reg)
            OP_NONE:     op_next = stat.reseed ? OP_REM_INCR : OP_REM_MULT;
            OP_REM_MULT: op_next = OP_REM_INCR;
            OP_REM_INCR: op_next = stat.reseed ? OP_REM_SEED : OP_REM_POS;
            OP_REM_POS:  op_next = loop_op(stat);
            OP_RC_STEP:  op_next = OP_RA_STEP;
            OP_RA_STEP:  op_next = OP_BC_STEP;
            OP_BC_STEP:  op_next = OP_BA_STEP;
            OP_BA_STEP:  op_next = loop_op(stat);
            OP_RC_LAST:  op_next = OP_RA_LAST;
            OP_RA_LAST:  op_next = OP_POS_LAST;
            default:     finish  = 1'b1;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.commit)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= OP_NONE;
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (finish)
                        state_reg <= ST_OUT;
                    else
                    begin
                        op_reg    <= op_next;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (stat.done)
                        state_reg <= ST_DECIDE;
                end
                ST_OUT:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign ctl.capture = in_ready && in_valid;
    assign ctl.start   = (state_reg == ST_ISSUE);
    assign ctl.op      = op_reg;
    assign ctl.commit  = (state_reg == ST_OUT) && out_free;

endmodule

`default_nettype wire

### design/lcg_random_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Linear congruential generator, x <- (a*x + c) mod m, exact product.
// Config: cfg_we/cfg_index/cfg_data write multiplier (0), increment (1) and
//   modulus (2; 0 means 2^64). Write only while idle.
// Input channel in_valid/in_ready carries cmd and operand. cmd 0 advances the
//   position operand+1 times and returns it; cmd 1 loads operand as the seed
//   (1 if seed and increment are both multiples of m) and returns it.
// Output channel out_valid/out_ready carries position, one result per item.
// One item at a time. All arithmetic runs through one bit-serial modular unit.
//   Reseed: 2 remainders. Generate: 3 remainders, then for each bit of the skip
//   count up to its top set bit 2 multiplies (4 when the bit is set), then 3
//   more multiplies.
// Reset: position 1, multiplier 0, increment 0, modulus 1, no result pending.
// A finished result waits in the output register while out_ready is low; the
//   next item is accepted meanwhile, and its result waits until the slot frees.
module lcg_random_generator_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lrg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lrg_pkg::DATA_W-1:0]      cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            cmd,
    input  wire logic [lrg_pkg::DATA_W-1:0]      operand,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [lrg_pkg::DATA_W-1:0]           position
);
    import lrg_pkg::*;

    ctrl_cmd_t  ctl;
    ctrl_stat_t stat;

    lrg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    lrg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .operand   (operand),
        .ctl       (ctl),
        .stat      (stat),
        .position  (position)
    );

endmodule

`default_nettype wire

### design/lrg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lrg_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lrg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lrg_pkg::DATA_W-1:0]      cfg_data,
    input  wire logic                            in_valid,
    input  wire logic                            in_ready,
    input  wire logic                            cmd,
    input  wire logic [lrg_pkg::DATA_W-1:0]      operand,
    input  wire logic                            out_valid,
    input  wire logic                            out_ready,
    input  wire logic [lrg_pkg::DATA_W-1:0]      position
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position))
        else $error("result changed or dropped while stalled");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

    // no result appears in the cycle right after an item is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

    // a new result is posted only as the block goes idle
    a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result posted while busy");

endmodule

bind lcg_random_generator_core lrg_checker u_lrg_checker (.*);

`default_nettype wire
